/* hw/rtl/mialu_pkg.sv */
// ---------------------------------------------------------------------------
// mialu_pkg
// shared types and operation codes for the integer alu with hi/lo
// ---------------------------------------------------------------------------
package mialu_pkg;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [4:0] {
      OP_SLL   = 5'd0,
      OP_SRL   = 5'd1,
      OP_SRA   = 5'd2,
      OP_SLLV  = 5'd3,
      OP_SRLV  = 5'd4,
      OP_SRAV  = 5'd5,
      OP_MFHI  = 5'd6,
      OP_MTHI  = 5'd7,
      OP_MFLO  = 5'd8,
      OP_MTLO  = 5'd9,
      OP_JR    = 5'd10,
      OP_DIV   = 5'd11,
      OP_DIVU  = 5'd12,
      OP_ADD   = 5'd13,
      OP_ADDU  = 5'd14,
      OP_SUB   = 5'd15,
      OP_SUBU  = 5'd16,
      OP_ADDI  = 5'd17,
      OP_ADDIU = 5'd18,
      OP_AND   = 5'd19,
      OP_OR    = 5'd20,
      OP_XOR   = 5'd21,
      OP_NOR   = 5'd22,
      OP_SLT   = 5'd23,
      OP_SLTU  = 5'd24,
      OP_ORI   = 5'd25
   } op_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] operand_s;
      logic [31:0] operand_t;
      logic [4:0]  shift_amount;
      logic [15:0] immediate;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        writes_register;
      logic        jump_taken;
      logic        overflow;
      logic        divide_by_zero;
   } rsp_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic        is_div;
      logic        div_signed;
      logic        is_mthi;
      logic        is_mtlo;
      logic        is_mfhi;
      logic        is_mflo;
      logic [31:0] a;
      logic [31:0] b;
      rsp_type     rsp;
   } work_type;

endpackage

/* hw/rtl/mialu_front.sv */
// ---------------------------------------------------------------------------
// mialu_front
// accepts requests, evaluates the arithmetic, logic, shift and jump operations, classifies the rest
// ---------------------------------------------------------------------------
module mialu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mialu_pkg::req_type  req_data,
   output logic                work_valid,
   input  logic                work_stall,
   output mialu_pkg::work_type work_data
);

   logic                work_valid_ff, work_valid_in;
   mialu_pkg::work_type work_ff, work_in;
   logic [31:0] s, t, simm, sum, diff, sumi, tr;
   logic [4:0]  vs;
   logic        accept;

   assign req_stall  = work_valid_ff && work_stall;
   assign accept     = req_valid && !req_stall;
   assign work_valid = work_valid_ff;
   assign work_data  = work_ff;

   always_comb begin
      s    = req_data.operand_s;
      t    = req_data.operand_t;
      vs   = s[4:0];
      simm = {{16{req_data.immediate[15]}}, req_data.immediate};
      sum  = s + t;
      diff = s - t;
      sumi = s + simm;
      tr   = '0;
      work_in = '0;
      work_in.a = s;
      work_in.b = t;
      work_in.rsp.writes_register = 1'b1;
      case (req_data.kind)
         mialu_pkg::OP_SLL:   work_in.rsp.result = t << req_data.shift_amount;
         mialu_pkg::OP_SRL:   work_in.rsp.result = t >> req_data.shift_amount;
         mialu_pkg::OP_SRA:   work_in.rsp.result = $unsigned($signed(t) >>> req_data.shift_amount);
         mialu_pkg::OP_SLLV:  work_in.rsp.result = t << vs;
         mialu_pkg::OP_SRLV:  work_in.rsp.result = t >> vs;
         mialu_pkg::OP_SRAV:  work_in.rsp.result = $unsigned($signed(t) >>> vs);
         mialu_pkg::OP_MFHI:  work_in.is_mfhi = 1'b1;
         mialu_pkg::OP_MFLO:  work_in.is_mflo = 1'b1;
         mialu_pkg::OP_MTHI: begin
            work_in.is_mthi = 1'b1;
            work_in.rsp.writes_register = 1'b0;
         end
         mialu_pkg::OP_MTLO: begin
            work_in.is_mtlo = 1'b1;
            work_in.rsp.writes_register = 1'b0;
         end
         mialu_pkg::OP_JR: begin
            work_in.rsp.result = s;
            work_in.rsp.writes_register = 1'b0;
            work_in.rsp.jump_taken = 1'b1;
         end
         mialu_pkg::OP_DIV, mialu_pkg::OP_DIVU: begin
            work_in.rsp.writes_register = 1'b0;
            work_in.rsp.divide_by_zero = (t == '0);
            work_in.is_div = (t != '0);
            work_in.div_signed = (req_data.kind == mialu_pkg::OP_DIV);
         end
         mialu_pkg::OP_ADD: begin
            work_in.rsp.result = sum;
            work_in.rsp.overflow = (s[31] ^ sum[31]) & (t[31] ^ sum[31]);
         end
         mialu_pkg::OP_ADDU:  work_in.rsp.result = sum;
         mialu_pkg::OP_SUB: begin
            work_in.rsp.result = diff;
            work_in.rsp.overflow = (s[31] ^ t[31]) & (s[31] ^ diff[31]);
         end
         mialu_pkg::OP_SUBU:  work_in.rsp.result = diff;
         mialu_pkg::OP_ADDI: begin
            work_in.rsp.result = sumi;
            work_in.rsp.overflow = (s[31] ^ sumi[31]) & (simm[31] ^ sumi[31]);
         end
         mialu_pkg::OP_ADDIU: work_in.rsp.result = sumi;
         mialu_pkg::OP_AND:   work_in.rsp.result = s & t;
         mialu_pkg::OP_OR:    work_in.rsp.result = s | t;
         mialu_pkg::OP_XOR:   work_in.rsp.result = s ^ t;
         mialu_pkg::OP_NOR:   work_in.rsp.result = ~(s | t);
         mialu_pkg::OP_SLT: begin
            tr[0] = $signed(s) < $signed(t);
            work_in.rsp.result = tr;
         end
         mialu_pkg::OP_SLTU: begin
            tr[0] = s < t;
            work_in.rsp.result = tr;
         end
         mialu_pkg::OP_ORI:   work_in.rsp.result = s | {16'h0000, req_data.immediate};
         default:             work_in.rsp.writes_register = 1'b0;
      endcase
      if (work_in.rsp.overflow) begin
         work_in.rsp.writes_register = 1'b0;
      end
      work_valid_in = accept ? 1'b1 : (work_valid_ff && work_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
      end
      if (accept) begin
         work_ff <= work_in;
      end
   end

endmodule

/* hw/rtl/mialu_queue.sv */
// ---------------------------------------------------------------------------
// mialu_queue
// small fifo between the front and back parts
// ---------------------------------------------------------------------------
module mialu_queue #(
   parameter int DEPTH = mialu_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  mialu_pkg::work_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output mialu_pkg::work_type out_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   mialu_pkg::work_type     mem_ff [DEPTH];
   logic [AW-1:0]           wr_ff, wr_in, rd_ff, rd_in;
   logic [$clog2(DEPTH+1)-1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_stall  = (cnt_ff == DEPTH[$clog2(DEPTH+1)-1:0]);
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule

/* hw/rtl/mialu_back.sv */
// ---------------------------------------------------------------------------
// mialu_back
// owns hi/lo, runs the radix-2 divider, holds the response register
// ---------------------------------------------------------------------------
module mialu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                work_valid,
   output logic                work_stall,
   input  mialu_pkg::work_type work_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mialu_pkg::rsp_type  rsp_data,
   output logic                busy
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        hi_ff, hi_in, lo_ff, lo_in;
   logic [31:0]        quo_ff, quo_in, dvs_ff, dvs_in;
   logic [32:0]        rem_ff, rem_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               nq_ff, nq_in, nr_ff, nr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mialu_pkg::rsp_type rsp_ff, rsp_in;
   logic [33:0]        trial;
   logic [32:0]        sh_rem;
   logic [31:0]        ma, mb;
   logic               out_free, take;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign work_stall = !(state_ff == ST_IDLE && out_free);
   assign take       = work_valid && !work_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign busy       = (state_ff == ST_DIV);

   always_comb begin
      state_in     = state_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      nq_in        = nq_ff;
      nr_in        = nr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ma = (work_data.div_signed && work_data.a[31]) ? -work_data.a : work_data.a;
      mb = (work_data.div_signed && work_data.b[31]) ? -work_data.b : work_data.b;
      sh_rem = {rem_ff[31:0], quo_ff[31]};
      trial  = {1'b0, sh_rem} - {2'b00, dvs_ff};
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               rsp_in = work_data.rsp;
               if (work_data.is_mfhi) begin
                  rsp_in.result = hi_ff;
               end
               if (work_data.is_mflo) begin
                  rsp_in.result = lo_ff;
               end
               if (work_data.is_mthi) begin
                  hi_in = work_data.a;
               end
               if (work_data.is_mtlo) begin
                  lo_in = work_data.a;
               end
               if (work_data.is_div) begin
                  state_in = ST_DIV;
                  quo_in   = ma;
                  dvs_in   = mb;
                  rem_in   = '0;
                  cnt_in   = '0;
                  nq_in    = work_data.div_signed && (work_data.a[31] ^ work_data.b[31]);
                  nr_in    = work_data.div_signed && work_data.a[31];
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (trial[33]) begin
               rem_in = sh_rem;
               quo_in = {quo_ff[30:0], 1'b0};
            end else begin
               rem_in = trial[32:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               state_in     = ST_IDLE;
               lo_in        = nq_ff ? -quo_in : quo_in;
               hi_in        = nr_ff ? -rem_in[31:0] : rem_in[31:0];
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hi_ff        <= '0;
         lo_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
      end
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      nq_ff  <= nq_in;
      nr_ff  <= nr_in;
      rsp_ff <= rsp_in;
   end

endmodule

/* hw/rtl/mips_integer_alu_hi_lo.sv */
// ---------------------------------------------------------------------------
// mips_integer_alu_hi_lo
// mips32 integer alu with hi/lo registers and an iterative divider
// ---------------------------------------------------------------------------
// req_ carries one instruction per transaction, rsp_ returns one result per
// transaction in order. both use valid/stall handshakes.
// the front registers a classified transaction, a small queue follows, and
// the back produces the response register. ops other than div/divu with a
// nonzero divisor pass through the front register, the queue and the
// response register before rsp_valid rises; one transaction per cycle is
// sustained while rsp_ is not stalled and no division is in progress.
// div/divu with nonzero divisor: the radix-2 divider in the back takes 32
// iterations, and the back accepts no work until the response is valid.
// reset clears hi, lo, the queue and all valid flags.
// a stalled rsp_ holds its payload; the queue then fills and req_stall rises.
// ---------------------------------------------------------------------------
module mips_integer_alu_hi_lo #(
   parameter int QUEUE_DEPTH = mialu_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mialu_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mialu_pkg::rsp_type rsp_data
);

   logic                fw_valid, fw_stall, qb_valid, qb_stall, busy;
   mialu_pkg::work_type fw_data, qb_data;

   mialu_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .work_valid(fw_valid), .work_stall(fw_stall), .work_data(fw_data)
   );

   mialu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .in_valid(fw_valid), .in_stall(fw_stall), .in_data(fw_data),
      .out_valid(qb_valid), .out_stall(qb_stall), .out_data(qb_data)
   );

   mialu_back u_back (
      .clock, .reset,
      .work_valid(qb_valid), .work_stall(qb_stall), .work_data(qb_data),
      .rsp_valid, .rsp_stall, .rsp_data, .busy
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed under stall");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      busy |-> qb_stall)
      else $error("back accepted work while dividing");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.overflow && rsp_data.writes_register))
      else $error("overflow with register write");

endmodule
